FILE: rtl/pcvs_pkg.sv
// shared constants and tables for the pose smoother
package pcvs_pkg;

	localparam int POSITION_WIDTH_DEF = 32;
	localparam int QUAT_WIDTH_DEF = 16;

	// request codes
	localparam logic [1:0] REQ_RAW = 2'd0;
	localparam logic [1:0] REQ_LOAD = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// configuration registers
	localparam int CFG_IDX_W = 4;
	localparam int NUM_REGS = 4;
	localparam logic [1:0] REG_POS_RAW = 2'd0;
	localparam logic [1:0] REG_POS_MODEL = 2'd1;
	localparam logic [1:0] REG_ROT_RAW = 2'd2;
	localparam logic [1:0] REG_ROT_MODEL = 2'd3;
	localparam logic [15:0] W_RAW_RST = 16'd25600;
	localparam logic [15:0] W_MODEL_RST = 16'd256;

	// fixed-point formats
	localparam int KFRAC = 15;
	localparam logic [15:0] K_ONE = 16'h8000;
	localparam int UNIT_FRAC = 30;
	localparam int DIV_STEPS = 31;
	localparam int SQRT_STEPS = 32;
	localparam int BISECT_TOP = 14;

	// hamilton product term order: output j/4, term j%4
	localparam logic [1:0] QM_A [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd0, 2'd2, 2'd3, 2'd1,
		2'd0, 2'd3, 2'd1, 2'd2
	};
	localparam logic [1:0] QM_B [16] = '{
		2'd0, 2'd1, 2'd2, 2'd3,
		2'd1, 2'd0, 2'd3, 2'd2,
		2'd2, 2'd0, 2'd1, 2'd3,
		2'd3, 2'd0, 2'd2, 2'd1
	};
	localparam logic [15:0] QM_NEG = 16'h888E;

endpackage

FILE: rtl/pose_constant_velocity_smoother.sv
// pose smoother top level: sequencer, shared multiplier, divider and square root
// Each request is accepted only when the block is idle and returns exactly one result.
// Clear, load, unknown codes and the first raw sample go straight to the result; the second
// raw sample runs one quaternion product; every later one computes both gains on the one
// shared divider, two quaternion products on the one multiplier and, for a rotation gain
// strictly between zero and one, a slerp of 17 normalizations, each a 32-step square root
// and four 31-step divisions. A finished result waits in the output register, so a new
// request is taken while it is still pending. Configuration writes are taken in any cycle.
module pose_constant_velocity_smoother #(
	parameter int POSITION_WIDTH = pcvs_pkg::POSITION_WIDTH_DEF,
	parameter int QUAT_WIDTH = pcvs_pkg::QUAT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] req_type,
	input logic signed [POSITION_WIDTH-1:0] pos_x,
	input logic signed [POSITION_WIDTH-1:0] pos_y,
	input logic signed [POSITION_WIDTH-1:0] pos_z,
	input logic signed [QUAT_WIDTH-1:0] quat_w,
	input logic signed [QUAT_WIDTH-1:0] quat_x,
	input logic signed [QUAT_WIDTH-1:0] quat_y,
	input logic signed [QUAT_WIDTH-1:0] quat_z,
	output logic out_valid,
	input logic out_ready,
	output logic signed [POSITION_WIDTH-1:0] out_pos_x,
	output logic signed [POSITION_WIDTH-1:0] out_pos_y,
	output logic signed [POSITION_WIDTH-1:0] out_pos_z,
	output logic signed [QUAT_WIDTH-1:0] out_quat_w,
	output logic signed [QUAT_WIDTH-1:0] out_quat_x,
	output logic signed [QUAT_WIDTH-1:0] out_quat_y,
	output logic signed [QUAT_WIDTH-1:0] out_quat_z,
	output logic signed [POSITION_WIDTH-1:0] out_vel_x,
	output logic signed [POSITION_WIDTH-1:0] out_vel_y,
	output logic signed [POSITION_WIDTH-1:0] out_vel_z,
	output logic [1:0] warmup_stage,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [pcvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_data
);

	localparam int PWD = POSITION_WIDTH;
	localparam int QWD = QUAT_WIDTH;
	localparam int QF = QWD - 2;
	localparam int QB1 = QWD + 1;
	localparam int MB = 33;
	localparam int MA = (PWD + 1 > MB) ? PWD + 1 : MB;
	localparam int RW = MA + MB;
	localparam int UW = 32;
	localparam int VW = 33;
	localparam int DQ = pcvs_pkg::DIV_STEPS;

	typedef logic signed [PWD-1:0] pos_t;
	typedef logic signed [QWD-1:0] quat_t;

	localparam logic signed [RW-1:0] P_MAX = $signed({{(RW-PWD+1){1'b0}}, {(PWD-1){1'b1}}});
	localparam logic signed [RW-1:0] P_MIN = ~P_MAX;
	localparam logic signed [RW-1:0] Q_MAX = $signed({{(RW-QWD+1){1'b0}}, {(QWD-1){1'b1}}});
	localparam logic signed [RW-1:0] Q_MIN = ~Q_MAX;
	localparam quat_t Q_ONE = quat_t'(QWD'(1) << QF);
	localparam logic signed [UW-1:0] UNIT = UW'(1) << pcvs_pkg::UNIT_FRAC;

	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_DISP = 5'd1;
	localparam logic [4:0] ST_GAIN = 5'd2;
	localparam logic [4:0] ST_DIV = 5'd3;
	localparam logic [4:0] ST_DIVEND = 5'd4;
	localparam logic [4:0] ST_POS = 5'd5;
	localparam logic [4:0] ST_QMUL = 5'd6;
	localparam logic [4:0] ST_QEND = 5'd7;
	localparam logic [4:0] ST_DOT = 5'd8;
	localparam logic [4:0] ST_SEL = 5'd9;
	localparam logic [4:0] ST_NSQ = 5'd10;
	localparam logic [4:0] ST_NSQRT = 5'd11;
	localparam logic [4:0] ST_NDIVSET = 5'd12;
	localparam logic [4:0] ST_NDONE = 5'd13;
	localparam logic [4:0] ST_FIN = 5'd14;
	localparam logic [4:0] ST_MOT = 5'd15;
	localparam logic [4:0] ST_DONE = 5'd16;

	localparam logic [1:0] QJ_MOT1 = 2'd0;
	localparam logic [1:0] QJ_PRED = 2'd1;
	localparam logic [1:0] QJ_MOT2 = 2'd2;

	localparam logic [1:0] ND_LO = 2'd0;
	localparam logic [1:0] ND_HI = 2'd1;
	localparam logic [1:0] ND_M = 2'd2;

	localparam logic DT_GAIN = 1'b0;
	localparam logic DT_NORM = 1'b1;

	function automatic logic signed [RW-1:0] rsh_r(input logic signed [RW-1:0] v, input int n);
		logic [RW-1:0] m;
		m = v[RW-1] ? RW'(-v) : RW'(v);
		m = (m + (RW'(1) << (n - 1))) >> n;
		return v[RW-1] ? -$signed(m) : $signed(m);
	endfunction

	function automatic pos_t sat_p(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] r;
		r = (v > P_MAX) ? P_MAX : ((v < P_MIN) ? P_MIN : v);
		return r[PWD-1:0];
	endfunction

	function automatic quat_t sat_q(input logic signed [RW-1:0] v);
		logic signed [RW-1:0] r;
		r = (v > Q_MAX) ? Q_MAX : ((v < Q_MIN) ? Q_MIN : v);
		return r[QWD-1:0];
	endfunction

	logic [4:0] state_q;
	logic [1:0] req_q;
	pos_t rp_q [3];
	quat_t rq_q [4];
	pos_t hp_q [3];
	quat_t hr_q [4];
	pos_t ml_q [3];
	quat_t ma_q [4];
	logic [1:0] stage_q;
	logic [15:0] w_q [4];
	pos_t np_q [3];
	quat_t pq_q [4];
	logic signed [QB1-1:0] bq_q [4];
	quat_t nq_q [4];
	logic [15:0] kp_q, kr_q;
	logic signed [UW-1:0] lo_q [4];
	logic signed [UW-1:0] hi_q [4];
	logic signed [VW-1:0] vec_q [4];
	logic [1:0] nd_q;
	logic [3:0] bit_q;
	logic [1:0] qjob_q;
	logic [3:0] cnt_q;
	logic ph_q;
	logic signed [RW-1:0] prod_q, acc_q;
	logic [63:0] sn_q, sr_q;
	logic [4:0] sit_q;
	logic [32:0] rem_q, den_q;
	logic [DQ-1:0] low_q, quo_q;
	logic [4:0] dcnt_q;
	logic dtag_q, dneg_q;

	logic out_valid_q;
	pos_t out_pos_q [3];
	quat_t out_quat_q [4];
	pos_t out_vel_q [3];
	logic [1:0] out_stage_q;

	logic [1:0] c2, ia, ib;
	logic signed [QB1-1:0] qa, qb;
	logic signed [MA-1:0] opa;
	logic signed [MB-1:0] opb;
	pos_t pred;
	logic signed [RW-1:0] dpos, qterm, qsum, asum;
	logic [63:0] sq_b, sq_t;
	logic [33:0] dv_t, dv_sub;
	logic dv_ge;
	logic signed [UW-1:0] dv_u;
	logic [16:0] gsum;
	logic [32:0] gnum;
	logic [15:0] gmodel;
	logic [32:0] nmag;
	logic dot_neg;
	logic signed [QB1-1:0] bsel [4];

	assign c2 = cnt_q[1:0];
	assign ia = pcvs_pkg::QM_A[cnt_q];
	assign ib = pcvs_pkg::QM_B[cnt_q];

	always_comb begin
		case (qjob_q)
			QJ_MOT1: qa = QB1'(rq_q[ia]);
			QJ_PRED: qa = QB1'(ma_q[ia]);
			default: qa = QB1'(nq_q[ia]);
		endcase
		if (qjob_q == QJ_PRED || ib == 2'd0) begin
			qb = QB1'(hr_q[ib]);
		end else begin
			qb = -QB1'(hr_q[ib]);
		end
	end

	always_comb begin
		pred = sat_p(RW'(hp_q[c2]) + RW'(ml_q[c2]));
		dpos = RW'(pred) - RW'(rp_q[c2]);
	end

	always_comb begin
		case (state_q)
			ST_QMUL: begin
				opa = MA'(qa);
				opb = MB'(qb);
			end
			ST_DOT: begin
				opa = MA'(rq_q[c2]);
				opb = MB'(pq_q[c2]);
			end
			ST_NSQ: begin
				opa = MA'(vec_q[c2]);
				opb = MB'(vec_q[c2]);
			end
			ST_POS: begin
				opa = $signed(dpos[MA-1:0]);
				opb = $signed(MB'(kp_q));
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= opa * opb;
	end

	always_comb begin
		qterm = pcvs_pkg::QM_NEG[cnt_q] ? -prod_q : prod_q;
		qsum = acc_q + qterm;
		asum = acc_q + prod_q;
		sq_b = 64'd1 << (6'd62 - {sit_q, 1'b0});
		sq_t = sr_q + sq_b;
		dv_t = {rem_q, low_q[DQ-1]};
		dv_ge = dv_t >= {1'b0, den_q};
		dv_sub = dv_t - {1'b0, den_q};
		dv_u = dneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		gmodel = cnt_q[0] ? w_q[pcvs_pkg::REG_ROT_MODEL] : w_q[pcvs_pkg::REG_POS_MODEL];
		gsum = {1'b0, cnt_q[0] ? w_q[pcvs_pkg::REG_ROT_RAW] : w_q[pcvs_pkg::REG_POS_RAW]}
			+ {1'b0, gmodel};
		gnum = {2'b00, gmodel, 15'd0} + 33'(gsum[16:1]);
		nmag = vec_q[c2][VW-1] ? 33'(-vec_q[c2]) : 33'(vec_q[c2]);
		dot_neg = acc_q[RW-1];
		for (int i = 0; i < 4; i++) begin
			bsel[i] = dot_neg ? -QB1'(pq_q[i]) : QB1'(pq_q[i]);
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			stage_q <= 2'd0;
			out_valid_q <= 1'b0;
			w_q[pcvs_pkg::REG_POS_RAW] <= pcvs_pkg::W_RAW_RST;
			w_q[pcvs_pkg::REG_POS_MODEL] <= pcvs_pkg::W_MODEL_RST;
			w_q[pcvs_pkg::REG_ROT_RAW] <= pcvs_pkg::W_RAW_RST;
			w_q[pcvs_pkg::REG_ROT_MODEL] <= pcvs_pkg::W_MODEL_RST;
			for (int i = 0; i < 3; i++) begin
				hp_q[i] <= '0;
				ml_q[i] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				hr_q[i] <= (i == 0) ? Q_ONE : '0;
				ma_q[i] <= (i == 0) ? Q_ONE : '0;
			end
		end else begin
			if (cfg_valid && cfg_index < pcvs_pkg::CFG_IDX_W'(pcvs_pkg::NUM_REGS)) begin
				w_q[cfg_index[1:0]] <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						req_q <= req_type;
						rp_q[0] <= pos_x;
						rp_q[1] <= pos_y;
						rp_q[2] <= pos_z;
						rq_q[0] <= quat_w;
						rq_q[1] <= quat_x;
						rq_q[2] <= quat_y;
						rq_q[3] <= quat_z;
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					cnt_q <= '0;
					ph_q <= 1'b0;
					acc_q <= '0;
					state_q <= ST_DONE;
					case (req_q)
						pcvs_pkg::REQ_CLEAR, pcvs_pkg::REQ_LOAD: begin
							for (int i = 0; i < 3; i++) begin
								hp_q[i] <= (req_q == pcvs_pkg::REQ_LOAD) ? rp_q[i] : '0;
								ml_q[i] <= '0;
							end
							for (int i = 0; i < 4; i++) begin
								if (req_q == pcvs_pkg::REQ_LOAD) begin
									hr_q[i] <= rq_q[i];
								end else begin
									hr_q[i] <= (i == 0) ? Q_ONE : '0;
								end
								ma_q[i] <= (i == 0) ? Q_ONE : '0;
							end
							stage_q <= (req_q == pcvs_pkg::REQ_LOAD) ? 2'd1 : 2'd0;
						end
						pcvs_pkg::REQ_RAW: begin
							if (stage_q == 2'd0) begin
								for (int i = 0; i < 3; i++) hp_q[i] <= rp_q[i];
								for (int i = 0; i < 4; i++) hr_q[i] <= rq_q[i];
								stage_q <= 2'd1;
							end else if (stage_q == 2'd1) begin
								for (int i = 0; i < 3; i++) begin
									ml_q[i] <= sat_p(RW'(rp_q[i]) - RW'(hp_q[i]));
								end
								qjob_q <= QJ_MOT1;
								state_q <= ST_QMUL;
							end else begin
								state_q <= ST_GAIN;
							end
						end
						default: ;
					endcase
				end
				ST_GAIN: begin
					if (gsum == 17'd0) begin
						if (cnt_q[0]) begin
							kr_q <= '0;
							cnt_q <= '0;
							state_q <= ST_POS;
						end else begin
							kp_q <= '0;
							cnt_q <= 4'd1;
						end
					end else begin
						rem_q <= 33'(gnum[32:DQ]);
						low_q <= gnum[DQ-1:0];
						den_q <= 33'(gsum);
						quo_q <= '0;
						dcnt_q <= '0;
						dtag_q <= DT_GAIN;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= dv_ge ? dv_sub[32:0] : dv_t[32:0];
					quo_q <= {quo_q[DQ-2:0], dv_ge};
					low_q <= {low_q[DQ-2:0], 1'b0};
					dcnt_q <= dcnt_q + 5'd1;
					if (dcnt_q == 5'(DQ - 1)) state_q <= ST_DIVEND;
				end
				ST_DIVEND: begin
					if (dtag_q == DT_GAIN) begin
						if (cnt_q[0]) begin
							kr_q <= quo_q[15:0];
							cnt_q <= '0;
							state_q <= ST_POS;
						end else begin
							kp_q <= quo_q[15:0];
							cnt_q <= 4'd1;
							state_q <= ST_GAIN;
						end
					end else begin
						case (nd_q)
							ND_LO: lo_q[c2] <= dv_u;
							ND_HI: hi_q[c2] <= dv_u;
							default: begin
								if (kr_q[bit_q]) lo_q[c2] <= dv_u;
								else hi_q[c2] <= dv_u;
							end
						endcase
						cnt_q <= cnt_q + 4'd1;
						state_q <= (c2 == 2'd3) ? ST_NDONE : ST_NDIVSET;
					end
				end
				ST_POS: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						np_q[c2] <= sat_p(RW'(rp_q[c2]) + rsh_r(prod_q, pcvs_pkg::KFRAC));
						if (c2 == 2'd2) begin
							cnt_q <= '0;
							acc_q <= '0;
							qjob_q <= QJ_PRED;
							state_q <= ST_QMUL;
						end else begin
							cnt_q <= cnt_q + 4'd1;
						end
					end
				end
				ST_QMUL: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (c2 == 2'd3) begin
							pq_q[cnt_q[3:2]] <= sat_q(rsh_r(qsum, QF));
							acc_q <= '0;
						end else begin
							acc_q <= qsum;
						end
						cnt_q <= cnt_q + 4'd1;
						if (cnt_q == 4'd15) state_q <= ST_QEND;
					end
				end
				ST_QEND: begin
					cnt_q <= '0;
					ph_q <= 1'b0;
					acc_q <= '0;
					if (qjob_q == QJ_PRED) begin
						state_q <= ST_DOT;
					end else begin
						for (int i = 0; i < 4; i++) begin
							ma_q[i] <= pq_q[i];
							hr_q[i] <= (qjob_q == QJ_MOT1) ? rq_q[i] : nq_q[i];
						end
						for (int i = 0; i < 3; i++) begin
							hp_q[i] <= (qjob_q == QJ_MOT1) ? rp_q[i] : np_q[i];
						end
						stage_q <= 2'd2;
						state_q <= ST_DONE;
					end
				end
				ST_DOT: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						acc_q <= asum;
						cnt_q <= cnt_q + 4'd1;
						if (c2 == 2'd3) state_q <= ST_SEL;
					end
				end
				ST_SEL: begin
					for (int i = 0; i < 4; i++) bq_q[i] <= bsel[i];
					cnt_q <= '0;
					ph_q <= 1'b0;
					acc_q <= '0;
					if (kr_q == 16'd0) begin
						for (int i = 0; i < 4; i++) nq_q[i] <= rq_q[i];
						state_q <= ST_MOT;
					end else if (kr_q >= pcvs_pkg::K_ONE) begin
						for (int i = 0; i < 4; i++) nq_q[i] <= sat_q(RW'(bsel[i]));
						state_q <= ST_MOT;
					end else begin
						for (int i = 0; i < 4; i++) vec_q[i] <= VW'(rq_q[i]);
						nd_q <= ND_LO;
						state_q <= ST_NSQ;
					end
				end
				ST_NSQ: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						acc_q <= asum;
						cnt_q <= cnt_q + 4'd1;
						if (c2 == 2'd3) begin
							sn_q <= asum[63:0];
							sr_q <= '0;
							sit_q <= '0;
							state_q <= ST_NSQRT;
						end
					end
				end
				ST_NSQRT: begin
					if (sn_q >= sq_t) begin
						sn_q <= sn_q - sq_t;
						sr_q <= (sr_q >> 1) + sq_b;
					end else begin
						sr_q <= sr_q >> 1;
					end
					sit_q <= sit_q + 5'd1;
					if (sit_q == 5'(pcvs_pkg::SQRT_STEPS - 1)) begin
						cnt_q <= '0;
						state_q <= ST_NDIVSET;
					end
				end
				ST_NDIVSET: begin
					if (sr_q == 64'd0) begin
						// zero vector normalizes to identity
						for (int i = 0; i < 4; i++) begin
							case (nd_q)
								ND_LO: lo_q[i] <= (i == 0) ? UNIT : '0;
								ND_HI: hi_q[i] <= (i == 0) ? UNIT : '0;
								default: begin
									if (kr_q[bit_q]) lo_q[i] <= (i == 0) ? UNIT : '0;
									else hi_q[i] <= (i == 0) ? UNIT : '0;
								end
							endcase
						end
						state_q <= ST_NDONE;
					end else begin
						rem_q <= 33'(nmag[32:1]);
						low_q <= {nmag[0], {(DQ-1){1'b0}}};
						den_q <= sr_q[32:0];
						dneg_q <= vec_q[c2][VW-1];
						quo_q <= '0;
						dcnt_q <= '0;
						dtag_q <= DT_NORM;
						state_q <= ST_DIV;
					end
				end
				ST_NDONE: begin
					cnt_q <= '0;
					ph_q <= 1'b0;
					acc_q <= '0;
					state_q <= ST_NSQ;
					case (nd_q)
						ND_LO: begin
							for (int i = 0; i < 4; i++) vec_q[i] <= VW'(bq_q[i]);
							nd_q <= ND_HI;
						end
						ND_HI: begin
							for (int i = 0; i < 4; i++) vec_q[i] <= VW'(lo_q[i]) + VW'(hi_q[i]);
							bit_q <= 4'(pcvs_pkg::BISECT_TOP);
							nd_q <= ND_M;
						end
						default: begin
							if (bit_q == 4'd0) begin
								state_q <= ST_FIN;
							end else begin
								for (int i = 0; i < 4; i++) begin
									vec_q[i] <= VW'(lo_q[i]) + VW'(hi_q[i]);
								end
								bit_q <= bit_q - 4'd1;
							end
						end
					endcase
				end
				ST_FIN: begin
					for (int i = 0; i < 4; i++) begin
						nq_q[i] <= sat_q(rsh_r(RW'(lo_q[i]), pcvs_pkg::UNIT_FRAC - QF));
					end
					state_q <= ST_MOT;
				end
				ST_MOT: begin
					for (int i = 0; i < 3; i++) begin
						ml_q[i] <= sat_p(RW'(np_q[i]) - RW'(hp_q[i]));
					end
					cnt_q <= '0;
					ph_q <= 1'b0;
					acc_q <= '0;
					qjob_q <= QJ_MOT2;
					state_q <= ST_QMUL;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						for (int i = 0; i < 3; i++) begin
							out_pos_q[i] <= hp_q[i];
							out_vel_q[i] <= ml_q[i];
						end
						for (int i = 0; i < 4; i++) out_quat_q[i] <= hr_q[i];
						out_stage_q <= stage_q;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_pos_x = out_pos_q[0];
	assign out_pos_y = out_pos_q[1];
	assign out_pos_z = out_pos_q[2];
	assign out_quat_w = out_quat_q[0];
	assign out_quat_x = out_quat_q[1];
	assign out_quat_y = out_quat_q[2];
	assign out_quat_z = out_quat_q[3];
	assign out_vel_x = out_vel_q[0];
	assign out_vel_y = out_vel_q[1];
	assign out_vel_z = out_vel_q[2];
	assign warmup_stage = out_stage_q;

	// divider remainder stays below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < den_q)
		else $error("divider remainder out of range");

	a_accept_disp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_DISP)
		else $error("accepted transfer not dispatched");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_POS |-> kp_q <= pcvs_pkg::K_ONE && kr_q <= pcvs_pkg::K_ONE)
		else $error("gain above one");

	a_motion_stage: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QEND && qjob_q != QJ_PRED |=> stage_q == 2'd2 && state_q == ST_DONE)
		else $error("motion update did not reach stage two");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && (!out_valid_q || out_ready) |=> out_valid_q && in_ready)
		else $error("result not presented");

endmodule
